@@ hw/rtl/scc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scc_pkg
// shared types and constants of the strongly connected components core
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = 6;
  localparam int CNT_W     = 7;
  localparam int ROW_W     = 64;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ROW_W-1:0]  row_t;

  // one call frame: node, next edge to scan, its low link and visit number
  typedef struct packed {
    node_t node;
    cnt_t  resume_w;
    cnt_t  low;
    cnt_t  vis;
  } frame_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_ROOT, ST_FETCH, ST_SCAN, ST_VISCMP, ST_RET, ST_POPR, ST_POPW,
    ST_UP, ST_PARENT, ST_OUTA, ST_OUTB, ST_OUTC, ST_OUTD
  } state_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_ROW, OP_START, OP_ROOT_NEXT, OP_ENTER_ROOT, OP_FETCH, OP_SKIP,
    OP_DESCEND, OP_VIS_RD, OP_VIS_CMP, OP_COMP_START, OP_POP_RD, OP_POP,
    OP_CALL_RD, OP_PARENT, OP_OUT_INIT, OP_OUT_RAW_RD, OP_OUT_MAP_RD,
    OP_OUT_LOAD, OP_OUT_NEXT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic root_done;
    logic root_visited;
    logic scan_end;
    logic edge_bit;
    logic w_visited;
    logic w_onstk;
    logic low_eq_vis;
    logic pop_end;
    logic depth_zero;
    logic out_last;
    logic out_taken;
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/scc_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scc channel interfaces
// valid/ready channels for rows, results and the node count register
// ----------------------------------------------------------------------------
interface scc_in_if;
  logic                 valid;
  logic                 ready;
  logic [5:0]           row_index;
  logic [63:0]          row_bits;
  logic                 last_row;
  modport source (output valid, row_index, row_bits, last_row, input ready);
  modport sink   (input valid, row_index, row_bits, last_row, output ready);
endinterface

interface scc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] node_index;
  logic [6:0] component_id;
  logic [6:0] member_count;
  logic       graph_is_acyclic;
  logic       last_result;
  modport source (output valid, node_index, component_id, member_count,
                  graph_is_acyclic, last_result, input ready);
  modport sink   (input valid, node_index, component_id, member_count,
                  graph_is_acyclic, last_result, output ready);
endinterface

interface scc_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] node_count;
  modport source (output valid, node_count, input ready);
  modport sink   (input valid, node_count, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/scc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scc_ctrl
// sequencer for row load, depth-first search and result emission
// ----------------------------------------------------------------------------
module scc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire scc_pkg::status_t sts,
  output scc_pkg::cmd_t         cmd
);

  scc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= scc_pkg::ST_LOAD;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = scc_pkg::OP_IDLE;
    cmd.in_ready = 1'b0;
    unique case (state_r)
      scc_pkg::ST_LOAD: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          if (sts.in_last) begin
            cmd.op    = scc_pkg::OP_START;
            state_nxt = scc_pkg::ST_ROOT;
          end else begin
            cmd.op = scc_pkg::OP_ROW;
          end
        end
      end
      scc_pkg::ST_ROOT: begin
        priority if (sts.root_done) begin
          cmd.op    = scc_pkg::OP_OUT_INIT;
          state_nxt = scc_pkg::ST_OUTA;
        end else if (sts.root_visited) begin
          cmd.op = scc_pkg::OP_ROOT_NEXT;
        end else begin
          cmd.op    = scc_pkg::OP_ENTER_ROOT;
          state_nxt = scc_pkg::ST_FETCH;
        end
      end
      scc_pkg::ST_FETCH: begin
        cmd.op    = scc_pkg::OP_FETCH;
        state_nxt = scc_pkg::ST_SCAN;
      end
      scc_pkg::ST_SCAN: begin
        priority if (sts.scan_end) begin
          state_nxt = scc_pkg::ST_RET;
        end else if (!sts.edge_bit) begin
          cmd.op = scc_pkg::OP_SKIP;
        end else if (!sts.w_visited) begin
          cmd.op    = scc_pkg::OP_DESCEND;
          state_nxt = scc_pkg::ST_FETCH;
        end else if (sts.w_onstk) begin
          cmd.op    = scc_pkg::OP_VIS_RD;
          state_nxt = scc_pkg::ST_VISCMP;
        end else begin
          cmd.op = scc_pkg::OP_SKIP;
        end
      end
      scc_pkg::ST_VISCMP: begin
        cmd.op    = scc_pkg::OP_VIS_CMP;
        state_nxt = scc_pkg::ST_SCAN;
      end
      scc_pkg::ST_RET: begin
        if (sts.low_eq_vis) begin
          cmd.op    = scc_pkg::OP_COMP_START;
          state_nxt = scc_pkg::ST_POPR;
        end else begin
          state_nxt = scc_pkg::ST_UP;
        end
      end
      scc_pkg::ST_POPR: begin
        cmd.op    = scc_pkg::OP_POP_RD;
        state_nxt = scc_pkg::ST_POPW;
      end
      scc_pkg::ST_POPW: begin
        cmd.op    = scc_pkg::OP_POP;
        state_nxt = sts.pop_end ? scc_pkg::ST_UP : scc_pkg::ST_POPR;
      end
      scc_pkg::ST_UP: begin
        if (sts.depth_zero) begin
          cmd.op    = scc_pkg::OP_ROOT_NEXT;
          state_nxt = scc_pkg::ST_ROOT;
        end else begin
          cmd.op    = scc_pkg::OP_CALL_RD;
          state_nxt = scc_pkg::ST_PARENT;
        end
      end
      scc_pkg::ST_PARENT: begin
        cmd.op    = scc_pkg::OP_PARENT;
        state_nxt = scc_pkg::ST_FETCH;
      end
      scc_pkg::ST_OUTA: begin
        cmd.op    = scc_pkg::OP_OUT_RAW_RD;
        state_nxt = scc_pkg::ST_OUTB;
      end
      scc_pkg::ST_OUTB: begin
        cmd.op    = scc_pkg::OP_OUT_MAP_RD;
        state_nxt = scc_pkg::ST_OUTC;
      end
      scc_pkg::ST_OUTC: begin
        cmd.op    = scc_pkg::OP_OUT_LOAD;
        state_nxt = scc_pkg::ST_OUTD;
      end
      scc_pkg::ST_OUTD: begin
        if (sts.out_taken) begin
          if (sts.out_last) begin
            state_nxt = scc_pkg::ST_LOAD;
          end else begin
            cmd.op    = scc_pkg::OP_OUT_NEXT;
            state_nxt = scc_pkg::ST_OUTA;
          end
        end
      end
      default: state_nxt = scc_pkg::ST_LOAD;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/scc_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scc_dp
// graph store, search stacks, per-node tables and result register
// ----------------------------------------------------------------------------
module scc_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire scc_pkg::cmd_t  cmd,
  output scc_pkg::status_t    sts,
  scc_in_if.sink              in_ch,
  scc_out_if.source           out_ch,
  scc_cfg_if.sink             cfg_ch
);

  // memories
  scc_pkg::row_t   adj_mem   [scc_pkg::MAX_NODES];
  scc_pkg::cnt_t   vis_mem   [scc_pkg::MAX_NODES];
  scc_pkg::node_t  nstk_mem  [scc_pkg::MAX_NODES];
  scc_pkg::frame_t call_mem  [scc_pkg::MAX_NODES];
  scc_pkg::node_t  raw_mem   [scc_pkg::MAX_NODES];
  scc_pkg::cnt_t   size_mem  [scc_pkg::MAX_NODES];
  scc_pkg::cnt_t   map_mem   [scc_pkg::MAX_NODES];

  scc_pkg::row_t   adj_q;
  scc_pkg::cnt_t   vis_q;
  scc_pkg::node_t  nstk_q;
  scc_pkg::frame_t call_q;
  scc_pkg::node_t  raw_q;
  scc_pkg::cnt_t   size_q;
  scc_pkg::cnt_t   map_q;

  // control state
  scc_pkg::cnt_t   node_count_r;
  logic [scc_pkg::MAX_NODES-1:0] visited_r, onstk_r, mapv_r;
  scc_pkg::cnt_t   root_r, w_r, low_r, visv_r, nsp_r, depth_r, nextvis_r;
  scc_pkg::cnt_t   nextraw_r, cnt_r, i_r, next_id_r;
  scc_pkg::node_t  v_r, r_r;
  scc_pkg::row_t   row_r;
  logic            selfloop_r, out_valid_r;
  scc_pkg::cnt_t   out_id_r, out_size_r;
  logic            out_acyc_r, out_last_r;

  scc_pkg::cnt_t   n;
  scc_pkg::cnt_t   ent_node;
  scc_pkg::node_t  ent_idx, w_idx, adj_rd_addr;
  logic            acyclic;

  always_comb begin
    priority if (node_count_r == '0) n = scc_pkg::CNT_W'(1);
    else if (node_count_r > scc_pkg::CNT_W'(scc_pkg::MAX_NODES))
      n = scc_pkg::CNT_W'(scc_pkg::MAX_NODES);
    else n = node_count_r;
  end

  assign w_idx    = w_r[scc_pkg::NODE_W-1:0];
  assign ent_node = (cmd.op == scc_pkg::OP_DESCEND) ? w_r : root_r;
  assign ent_idx  = ent_node[scc_pkg::NODE_W-1:0];
  assign acyclic  = !selfloop_r && (nextraw_r == n);

  always_comb begin
    unique case (cmd.op)
      scc_pkg::OP_PARENT: adj_rd_addr = call_q.node;
      default:            adj_rd_addr = ent_idx;
    endcase
  end

  always_comb begin
    sts.in_valid     = in_ch.valid;
    sts.in_last      = in_ch.last_row;
    sts.root_done    = root_r == n;
    sts.root_visited = visited_r[root_r[scc_pkg::NODE_W-1:0]];
    sts.scan_end     = w_r == n;
    sts.edge_bit     = row_r[w_idx];
    sts.w_visited    = visited_r[w_idx];
    sts.w_onstk      = onstk_r[w_idx];
    sts.low_eq_vis   = low_r == visv_r;
    sts.pop_end      = (nstk_q == v_r) || (nsp_r == scc_pkg::CNT_W'(1));
    sts.depth_zero   = depth_r == '0;
    sts.out_last     = (i_r + scc_pkg::CNT_W'(1)) == n;
    sts.out_taken    = out_valid_r && out_ch.ready;
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.op == scc_pkg::OP_ROW || cmd.op == scc_pkg::OP_START)
      adj_mem[in_ch.row_index] <= in_ch.row_bits;
    adj_q <= adj_mem[adj_rd_addr];

    if (cmd.op == scc_pkg::OP_ENTER_ROOT || cmd.op == scc_pkg::OP_DESCEND) begin
      vis_mem[ent_idx]                             <= nextvis_r;
      nstk_mem[nsp_r[scc_pkg::NODE_W-1:0]]         <= ent_idx;
    end
    vis_q  <= vis_mem[w_idx];
    nstk_q <= nstk_mem[6'(nsp_r - scc_pkg::CNT_W'(1))];

    if (cmd.op == scc_pkg::OP_DESCEND)
      call_mem[depth_r[scc_pkg::NODE_W-1:0]] <=
        '{node: v_r, resume_w: w_r + scc_pkg::CNT_W'(1), low: low_r, vis: visv_r};
    call_q <= call_mem[6'(depth_r - scc_pkg::CNT_W'(1))];

    if (cmd.op == scc_pkg::OP_POP) begin
      raw_mem[nstk_q] <= nextraw_r[scc_pkg::NODE_W-1:0];
      if (sts.pop_end)
        size_mem[nextraw_r[scc_pkg::NODE_W-1:0]] <= cnt_r + scc_pkg::CNT_W'(1);
    end
    raw_q  <= raw_mem[i_r[scc_pkg::NODE_W-1:0]];
    size_q <= size_mem[raw_q];

    if (cmd.op == scc_pkg::OP_OUT_LOAD && !mapv_r[r_r]) map_mem[r_r] <= next_id_r;
    map_q <= map_mem[raw_q];
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.op == scc_pkg::OP_OUT_LOAD) begin
      out_id_r   <= mapv_r[r_r] ? map_q : next_id_r;
      out_size_r <= size_q;
      out_acyc_r <= acyclic;
      out_last_r <= sts.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= scc_pkg::CNT_W'(scc_pkg::MAX_NODES);
      visited_r    <= '0;
      onstk_r      <= '0;
      mapv_r       <= '0;
      root_r       <= '0;
      w_r          <= '0;
      low_r        <= '0;
      visv_r       <= '0;
      v_r          <= '0;
      r_r          <= '0;
      row_r        <= '0;
      nsp_r        <= '0;
      depth_r      <= '0;
      nextvis_r    <= scc_pkg::CNT_W'(1);
      nextraw_r    <= '0;
      cnt_r        <= '0;
      i_r          <= '0;
      next_id_r    <= scc_pkg::CNT_W'(1);
      selfloop_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) node_count_r <= cfg_ch.node_count;
      if (sts.out_taken) out_valid_r <= 1'b0;
      unique case (cmd.op)
        scc_pkg::OP_START: begin
          visited_r  <= '0;
          onstk_r    <= '0;
          root_r     <= '0;
          nsp_r      <= '0;
          depth_r    <= '0;
          nextvis_r  <= scc_pkg::CNT_W'(1);
          nextraw_r  <= '0;
          selfloop_r <= 1'b0;
        end
        scc_pkg::OP_ROOT_NEXT: root_r <= root_r + scc_pkg::CNT_W'(1);
        scc_pkg::OP_ENTER_ROOT, scc_pkg::OP_DESCEND: begin
          if (cmd.op == scc_pkg::OP_DESCEND) depth_r <= depth_r + scc_pkg::CNT_W'(1);
          visited_r[ent_idx] <= 1'b1;
          onstk_r[ent_idx]   <= 1'b1;
          nsp_r     <= nsp_r + scc_pkg::CNT_W'(1);
          v_r       <= ent_idx;
          w_r       <= '0;
          low_r     <= nextvis_r;
          visv_r    <= nextvis_r;
          nextvis_r <= nextvis_r + scc_pkg::CNT_W'(1);
        end
        scc_pkg::OP_FETCH: row_r <= adj_q;
        scc_pkg::OP_SKIP:  w_r <= w_r + scc_pkg::CNT_W'(1);
        scc_pkg::OP_VIS_RD: if (w_idx == v_r) selfloop_r <= 1'b1;
        scc_pkg::OP_VIS_CMP: begin
          if (vis_q < low_r) low_r <= vis_q;
          w_r <= w_r + scc_pkg::CNT_W'(1);
        end
        scc_pkg::OP_COMP_START: cnt_r <= '0;
        scc_pkg::OP_POP: begin
          onstk_r[nstk_q] <= 1'b0;
          nsp_r <= nsp_r - scc_pkg::CNT_W'(1);
          cnt_r <= cnt_r + scc_pkg::CNT_W'(1);
          if (sts.pop_end) nextraw_r <= nextraw_r + scc_pkg::CNT_W'(1);
        end
        scc_pkg::OP_PARENT: begin
          if (call_q.low < low_r) low_r <= call_q.low;
          v_r     <= call_q.node;
          w_r     <= call_q.resume_w;
          visv_r  <= call_q.vis;
          depth_r <= depth_r - scc_pkg::CNT_W'(1);
        end
        scc_pkg::OP_OUT_INIT: begin
          i_r       <= '0;
          mapv_r    <= '0;
          next_id_r <= scc_pkg::CNT_W'(1);
        end
        scc_pkg::OP_OUT_MAP_RD: r_r <= raw_q;
        scc_pkg::OP_OUT_LOAD: begin
          out_valid_r <= 1'b1;
          if (!mapv_r[r_r]) begin
            mapv_r[r_r] <= 1'b1;
            next_id_r   <= next_id_r + scc_pkg::CNT_W'(1);
          end
        end
        scc_pkg::OP_OUT_NEXT: i_r <= i_r + scc_pkg::CNT_W'(1);
        default: ;
      endcase
    end
  end

  assign in_ch.ready             = cmd.in_ready;
  assign cfg_ch.ready            = 1'b1;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.node_index       = i_r[scc_pkg::NODE_W-1:0];
  assign out_ch.component_id     = out_id_r;
  assign out_ch.member_count     = out_size_r;
  assign out_ch.graph_is_acyclic = out_acyc_r;
  assign out_ch.last_result      = out_last_r;

endmodule
`default_nettype wire

@@ hw/rtl/strongly_connected_components_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// strongly_connected_components_core
// tarjan component search over a loaded adjacency matrix, one result per node
// ----------------------------------------------------------------------------
// rows: ready stays high while loading; the last row starts the search
// search: each node is entered, its row fetched and each bit below n scanned;
//   then come the root test, the stack pop and the unwind to the parent;
//   edges into the node stack add a visit compare; visited roots are skipped
// emission: two reads and a load per result, held until the sink takes it
// reset: node count 64, stacks empty, no result pending; rows undefined
module strongly_connected_components_core (
  input wire logic  clk,
  input wire logic  rst_n,
  scc_in_if.sink    in_ch,
  scc_out_if.source out_ch,
  scc_cfg_if.sink   cfg_ch
);

  // command and status between sequencer and datapath
  scc_pkg::cmd_t    cmd;
  scc_pkg::status_t sts;

  scc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // graph store, stacks and result register
  scc_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

endmodule
`default_nettype wire

@@ dv/scc_tb_if.sv @@
// ----------------------------------------------------------------------------
// scc testbench channel wrappers
// instances of the core's channel interfaces are used directly; this file
// only holds a small package of row item and result types for the predictor
// ----------------------------------------------------------------------------
package scc_tb_pkg;
  typedef struct packed {
    logic [5:0] node_index;
    logic [6:0] component_id;
    logic [6:0] member_count;
    logic       graph_is_acyclic;
    logic       last_result;
  } node_result_t;

  typedef struct packed {
    logic [5:0]  row_index;
    logic [63:0] row_bits;
    logic        last_row;
  } row_item_t;
endpackage

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// loads random and directed graphs row by row into the scc core, predicts
// the component labelling of every node and checks each result in order
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int LONG_HOLD      = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  scc_in_if  in_ch();
  scc_out_if out_ch();
  scc_cfg_if cfg_ch();

  strongly_connected_components_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---- predictor state ----
  logic [63:0] graph_rows [scc_pkg::MAX_NODES];
  int          nodes_in_use = 64;

  scc_tb_pkg::node_result_t expected_results[$];
  scc_tb_pkg::row_item_t    pending_rows[$];

  int  error_count = 0;
  int  results_seen = 0;
  int  rows_sent = 0;
  int  graphs_run = 0;
  int  idle_cycles = 0;
  bit  in_taken = 1'b0;
  bit  stall_req = 1'b0;
  bit  stall_done = 1'b0;
  int  hold_left = 0;

  // tarjan search with explicit stacks, then dense renumbering by lowest node
  task automatic label_components();
    int n;
    int vis [scc_pkg::MAX_NODES];
    int low [scc_pkg::MAX_NODES];
    bit onstk [scc_pkg::MAX_NODES];
    int nstack [$];
    int cnode [$];
    int cedge [$];
    int raw [scc_pkg::MAX_NODES];
    int remap [scc_pkg::MAX_NODES];
    int members [scc_pkg::MAX_NODES+1];
    int fin [scc_pkg::MAX_NODES];
    int next_vis, next_raw, next_id, v, w, x;
    bit acyclic;
    scc_tb_pkg::node_result_t res;
    n = nodes_in_use;
    if (n < 1) n = 1;
    if (n > scc_pkg::MAX_NODES) n = scc_pkg::MAX_NODES;
    for (int i = 0; i < scc_pkg::MAX_NODES; i++) begin
      vis[i] = 0; low[i] = 0; onstk[i] = 0; raw[i] = 0; remap[i] = 0;
    end
    next_vis = 1; next_raw = 0;
    for (int root = 0; root < n; root++) begin
      if (vis[root] != 0) continue;
      vis[root] = next_vis; low[root] = next_vis; next_vis++;
      nstack.push_back(root); onstk[root] = 1;
      cnode.push_back(root); cedge.push_back(0);
      while (cnode.size() > 0) begin
        v = cnode[$]; w = cedge[$];
        while (w < n && !graph_rows[v][w]) w++;
        if (w < n) begin
          cedge[$] = w + 1;
          if (vis[w] == 0) begin
            vis[w] = next_vis; low[w] = next_vis; next_vis++;
            nstack.push_back(w); onstk[w] = 1;
            cnode.push_back(w); cedge.push_back(0);
          end else if (onstk[w] && low[v] > vis[w]) begin
            low[v] = vis[w];
          end
          continue;
        end
        void'(cnode.pop_back()); void'(cedge.pop_back());
        if (low[v] == vis[v]) begin
          do begin
            x = nstack.pop_back();
            onstk[x] = 0;
            raw[x] = next_raw & 63;
          end while (x != v);
          next_raw++;
        end
        if (cnode.size() > 0 && low[cnode[$]] > low[v]) low[cnode[$]] = low[v];
      end
    end
    for (int i = 0; i <= scc_pkg::MAX_NODES; i++) members[i] = 0;
    next_id = 1; acyclic = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (remap[raw[i]] == 0) remap[raw[i]] = next_id++;
      fin[i] = remap[raw[i]];
      members[fin[i]]++;
      if (graph_rows[i][i]) acyclic = 1'b0;
    end
    if (next_id - 1 != n) acyclic = 1'b0;
    for (int i = 0; i < n; i++) begin
      res.node_index       = 6'(i);
      res.component_id     = 7'(fin[i]);
      res.member_count     = 7'(members[fin[i]]);
      res.graph_is_acyclic = acyclic;
      res.last_result      = (i == n - 1);
      expected_results.push_back(res);
    end
    graphs_run++;
  endtask

  // applied at acceptance, in the same order as the core sees rows
  task automatic accept_row(input scc_tb_pkg::row_item_t item);
    graph_rows[item.row_index] = item.row_bits;
    if (item.last_row) label_components();
  endtask

  // ---- driver: bursts with random gaps ----
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // hold the item until it is taken
    end else begin
      if (in_ch.valid) void'(pending_rows.pop_front());
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_rows.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid     <= 1'b1;
        in_ch.row_index <= pending_rows[0].row_index;
        in_ch.row_bits  <= pending_rows[0].row_bits;
        in_ch.last_row  <= pending_rows[0].last_row;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // ---- receiver ready pattern, with one long hold-off on request ----
  int stall_phase = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_req && !stall_done) begin
      hold_left  = LONG_HOLD;
      stall_done = 1'b1;
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 64;
      if (stall_phase < 20) out_ch.ready <= 1'b1;
      else if (stall_phase < 40) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else out_ch.ready <= ($urandom_range(0, 1) != 0);
    end
  end

  // ---- monitor: sample at the rising edge ----
  scc_tb_pkg::node_result_t got, want;
  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      rows_sent++;
      accept_row(scc_tb_pkg::row_item_t'{in_ch.row_index, in_ch.row_bits,
                                         in_ch.last_row});
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.node_index, out_ch.component_id, out_ch.member_count,
              out_ch.graph_is_acyclic, out_ch.last_result};
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result for node %0d", got.node_index);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.node_index !== want.node_index) begin
          $error("node_index exp %0d got %0d", want.node_index, got.node_index);
          error_count++;
        end
        if (got.component_id !== want.component_id) begin
          $error("component_id exp %0d got %0d", want.component_id, got.component_id);
          error_count++;
        end
        if (got.member_count !== want.member_count) begin
          $error("member_count exp %0d got %0d", want.member_count,
                 got.member_count);
          error_count++;
        end
        if (got.graph_is_acyclic !== want.graph_is_acyclic) begin
          $error("graph_is_acyclic exp %0d got %0d", want.graph_is_acyclic,
                 got.graph_is_acyclic);
          error_count++;
        end
        if (got.last_result !== want.last_result) begin
          $error("last_result exp %0d got %0d", want.last_result, got.last_result);
          error_count++;
        end
      end
    end
  end

  // ---- watchdog: cycles with nothing accepted ----
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || hold_left > 0) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding",
               expected_results.size());
      $display("strongly_connected_components_core: mismatch");
      $finish;
    end
  end

  // ---- stimulus helpers ----
  // queue a whole graph of n nodes; every row in use is written first
  task automatic queue_graph(input int n, input int style);
    scc_tb_pkg::row_item_t item;
    int order [$];
    for (int i = 0; i < n; i++) order.push_back(i);
    order.shuffle();
    foreach (order[k]) begin
      item.row_index = 6'(order[k]);
      case (style)
        0: item.row_bits = {$urandom, $urandom};
        1: item.row_bits = {$urandom, $urandom} & {$urandom, $urandom}
                           & {$urandom, $urandom};
        2: item.row_bits = 64'd1 << ((order[k] + 1) % n);            // one ring
        3: item.row_bits = (order[k] + 1 < n) ? 64'd1 << (order[k] + 1) : '0; // chain
        4: item.row_bits = '0;
        5: item.row_bits = '1;
        default: item.row_bits = 64'd1 << $urandom_range(0, 63);
      endcase
      item.last_row = (k == order.size() - 1);
      pending_rows.push_back(item);
    end
  endtask

  task automatic wait_drained();
    while (pending_rows.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_node_count(input int value);
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.node_count <= 7'(value);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    nodes_in_use = value;
  endtask

  initial begin
    scc_tb_pkg::row_item_t item;
    int n;
    in_ch.valid = 1'b0; in_ch.row_index = '0; in_ch.row_bits = '0;
    in_ch.last_row = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.node_count = '0;
    for (int i = 0; i < scc_pkg::MAX_NODES; i++) graph_rows[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: full 64-node graphs with reset count
    queue_graph(64, 5);             // every edge, incl self-loops
    queue_graph(64, 3);             // chain, acyclic
    wait_drained();
    // extremes of the count register
    write_node_count(1);
    item = '{6'd0, 64'd0, 1'b1}; pending_rows.push_back(item);     // lone node
    item = '{6'd0, 64'd1, 1'b1}; pending_rows.push_back(item);     // self-loop
    item = '{6'd63, '1, 1'b1};   pending_rows.push_back(item);     // row outside count
    wait_drained();
    write_node_count(0);            // taken as one
    item = '{6'd0, '1, 1'b1};    pending_rows.push_back(item);
    wait_drained();
    write_node_count(127);          // clamped to the maximum
    queue_graph(64, 2);             // single ring
    wait_drained();
    write_node_count(5);
    queue_graph(5, 4);              // no edges
    queue_graph(5, 2);
    // pressure: hold the receiver off while the sender keeps offering rows
    stall_req = 1'b1;
    queue_graph(5, 0);
    queue_graph(5, 1);
    wait (stall_done && hold_left == 0);
    wait_drained();

    // random part: small graphs until the row budget is used
    while (rows_sent < 260) begin
      n = $urandom_range(1, 10);
      write_node_count(n);
      repeat ($urandom_range(1, 3)) queue_graph(n, $urandom_range(0, 6));
      wait_drained();
    end

    $display("ran %0d graphs from %0d rows, %0d node results checked, counts 1 to 64",
             graphs_run, rows_sent, results_seen);
    if (error_count == 0) $display("strongly_connected_components_core: match");
    else $display("strongly_connected_components_core: mismatch");
    $finish;
  end
endmodule

@@ strongly_connected_components_core.f @@
hw/rtl/scc_pkg.sv
hw/rtl/scc_if.sv
hw/rtl/scc_ctrl.sv
hw/rtl/scc_dp.sv
hw/rtl/strongly_connected_components_core.sv
dv/scc_tb_if.sv
dv/testbench.sv
